[src/vob_pkg.sv]
// Package for the orthonormal basis block: word types, pipeline constants
// and the Q4.28 to Q2.14 round/saturate helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vob_pkg;

  localparam int NDIG = 16;
  localparam int Y_LIMIT = 16382;
  localparam logic signed [15:0] Q_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_t;

  typedef struct packed {
    logic               br1;
    logic               zero;
    logic               neg_a;
    logic               neg_c;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
  } side_t;

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] p);
    logic signed [34:0] t;
    logic signed [20:0] r;
    t = 35'(p) + 35'sd8192;
    r = 21'(t >>> 14);
    if (r > 21'sd16384) begin
      return Q_ONE;
    end else if (r < -21'sd16384) begin
      return -Q_ONE;
    end
    return 16'(r);
  endfunction

endpackage
`default_nettype wire

[src/vec3_orthonormal_basis.sv]
// Top level: orthonormal basis (right, up) from a Q2.14 direction word.
// Depends on vob_pkg and vob_root_div.
// Fully pipelined: one word per cycle unless the output stalls; depth is set by
// the 16-stage bit-per-stage root/divide lanes. in_ready = !out_valid | out_ready.
`timescale 1ns / 1ps
`default_nettype none
module vec3_orthonormal_basis
  import vob_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int DEPTH = NDIG + 6;

  logic en;
  logic [DEPTH-1:0] vld_r;
  assign en = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // stage 1: branch select, magnitudes
  side_t sd1_r, sd2_r, sd3_r;
  logic [15:0] ma_r, mc_r;
  logic br1;
  logic signed [16:0] a_v, c_v;
  assign br1 = (in_data.dir_y <= 16'(Y_LIMIT)) && (in_data.dir_y >= -16'(Y_LIMIT));
  assign a_v = 17'(in_data.dir_z);
  assign c_v = br1 ? -17'(in_data.dir_x) : -17'(in_data.dir_y);

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r.br1   <= br1;
      sd1_r.zero  <= 1'b0;
      sd1_r.neg_a <= a_v[16];
      sd1_r.neg_c <= c_v[16];
      sd1_r.dx    <= in_data.dir_x;
      sd1_r.dy    <= in_data.dir_y;
      sd1_r.dz    <= in_data.dir_z;
      ma_r <= 16'(a_v[16] ? -a_v : a_v);
      mc_r <= 16'(c_v[16] ? -c_v : c_v);
    end
  end

  // stage 2: squares
  logic [31:0] sqa_r, sqc_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r <= sd1_r;
      sqa_r <= ma_r * ma_r;
      sqc_r <= mc_r * mc_r;
    end
  end

  // stage 3: squared length
  logic [31:0] s_r;
  logic [61:0] ra_r, rc_r;
  logic [31:0] s_sum;
  side_t sd3_nxt;
  assign s_sum = sqa_r + sqc_r;
  always_comb begin
    sd3_nxt = sd2_r;
    sd3_nxt.zero = (s_sum == '0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r <= sd3_nxt;
      s_r  <= s_sum;
      ra_r <= 62'(sqa_r) << 30;
      rc_r <= 62'(sqc_r) << 30;
    end
  end

  logic [15:0] na, nc;
  vob_root_div u_div_a (.clk(clk), .en(en), .r_in(ra_r), .s_in(s_r), .n_out(na));
  vob_root_div u_div_c (.clk(clk), .en(en), .r_in(rc_r), .s_in(s_r), .n_out(nc));

  side_t sdl_r [NDIG];
  always_ff @(posedge clk) begin
    if (en) begin
      sdl_r[0] <= sd3_r;
      for (int i = 1; i < NDIG; i++) begin
        sdl_r[i] <= sdl_r[i-1];
      end
    end
  end

  // rounding and sign
  side_t sd4_r, sd5_r;
  logic signed [15:0] rna_r, rnc_r;
  logic [15:0] qa, qc;
  assign qa = 16'((17'(na) + 17'd1) >> 1);
  assign qc = 16'((17'(nc) + 17'd1) >> 1);
  always_ff @(posedge clk) begin
    if (en) begin
      sd4_r <= sdl_r[NDIG-1];
      if (sdl_r[NDIG-1].zero) begin
        rna_r <= '0;
        rnc_r <= '0;
      end else begin
        rna_r <= sdl_r[NDIG-1].neg_a ? -$signed(qa) : $signed(qa);
        rnc_r <= sdl_r[NDIG-1].neg_c ? -$signed(qc) : $signed(qc);
      end
    end
  end

  // cross products
  logic signed [31:0] p0_r, p1a_r, p1b_r, p2_r;
  logic signed [15:0] rna5_r, rnc5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sd5_r  <= sd4_r;
      rna5_r <= rna_r;
      rnc5_r <= rnc_r;
      p0_r   <= sd4_r.dy * rnc_r;
      p1a_r  <= sd4_r.dz * rna_r;
      p1b_r  <= sd4_r.dx * rnc_r;
      p2_r   <= sd4_r.dy * rna_r;
    end
  end

  // round, saturate, output register
  out_t out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.right_y <= '0;
      if (sd5_r.br1) begin
        out_r.right_x <= rna5_r;
        out_r.right_z <= rnc5_r;
        out_r.up_x    <= to_q14(34'(p0_r));
        out_r.up_y    <= to_q14(34'(p1a_r) - 34'(p1b_r));
        out_r.up_z    <= to_q14(-34'(p2_r));
      end else begin
        out_r.right_x <= Q_ONE;
        out_r.right_z <= '0;
        out_r.up_x    <= '0;
        out_r.up_y    <= rna5_r;
        out_r.up_z    <= rnc5_r;
      end
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = out_r;

endmodule
`default_nettype wire

[src/vob_root_div.sv]
// One lane of the pipelined normalize divider: finds the largest n with
// n*n*s <= r, one bit per stage, NDIG stages. Depends on vob_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vob_root_div
  import vob_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [61:0] r_in,
  input  wire logic [31:0] s_in,
  output logic      [15:0] n_out
);

  logic [63:0] e_r [NDIG];
  logic [47:0] m_r [NDIG];
  logic [31:0] s_r [NDIG];
  logic [15:0] n_r [NDIG];

  for (genvar i = 0; i < NDIG; i++) begin : g_stg
    localparam int K = NDIG - 1 - i;
    logic [63:0] e_p;
    logic [47:0] m_p;
    logic [31:0] s_p;
    logic [15:0] n_p;
    logic [65:0] delta;
    if (i == 0) begin : g_first
      assign e_p = 64'(r_in);
      assign m_p = '0;
      assign s_p = s_in;
      assign n_p = '0;
    end else begin : g_next
      assign e_p = e_r[i-1];
      assign m_p = m_r[i-1];
      assign s_p = s_r[i-1];
      assign n_p = n_r[i-1];
    end
    assign delta = (66'(m_p) << (K + 1)) + (66'(s_p) << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[i] <= s_p;
        if (delta <= 66'(e_p)) begin
          e_r[i] <= 64'(66'(e_p) - delta);
          m_r[i] <= 48'(m_p + (48'(s_p) << K));
          n_r[i] <= n_p | (16'd1 << K);
        end else begin
          e_r[i] <= e_p;
          m_r[i] <= m_p;
          n_r[i] <= n_p;
        end
      end
    end
  end

  assign n_out = n_r[NDIG-1];

endmodule
`default_nettype wire

[src/vob_checker.sv]
// Port-level checker for vec3_orthonormal_basis, bound to the top level.
// Depends on vob_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vob_checker
  import vob_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_ry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.right_y == 16'sd0)
    else $error("right_y nonzero");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.up_x <= Q_ONE && out_data.up_x >= -Q_ONE &&
                  out_data.up_y <= Q_ONE && out_data.up_y >= -Q_ONE &&
                  out_data.up_z <= Q_ONE && out_data.up_z >= -Q_ONE)
    else $error("up vector out of range");

endmodule

bind vec3_orthonormal_basis vob_checker u_vob_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

[sim/vec3_orthonormal_basis_test.sv]
// Testbench for vec3_orthonormal_basis: directed table plus random direction
// words, checked against table expectations or an in-bench basis predictor. Depends on vob_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vec3_orthonormal_basis_test;
  import vob_pkg::*;

  localparam int LATENCY = 22;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1030;
  localparam int QUIET_TAIL = 200;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t basis_q[$];
  int   n_errors;
  int   idle_cycles;
  bit   stim_done;
  bit   quiet;
  bit   hold_done;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    bit                 has_exp;
    out_t               exp;
  } vec_row_t;

  vec3_orthonormal_basis i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // round(v * 2^14 / sqrt(s)), ties away from zero
  function automatic logic signed [15:0] unit_comp(longint v, longint unsigned s);
    longint unsigned mag;
    longint unsigned rhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned t;
    if (s == 0) return 16'sd0;
    mag = (v < 0) ? -v : v;
    rhs = 4 * mag * mag * (64'd1 << 28);
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      if (t * t * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (v < 0) ? -16'(lo) : 16'(lo);
  endfunction

  function automatic logic signed [15:0] q28_to_q14(longint p);
    longint r;
    r = (p + 8192) >>> 14;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic out_t predict_basis(in_t d);
    out_t   o;
    longint dx;
    longint dy;
    longint dz;
    longint rx;
    longint rz;
    longint unsigned s;
    dx = d.dir_x;
    dy = d.dir_y;
    dz = d.dir_z;
    o = '0;
    if (dy <= Y_LIMIT && dy >= -Y_LIMIT) begin
      s = dz * dz + dx * dx;
      o.right_x = unit_comp(dz, s);
      o.right_z = unit_comp(-dx, s);
      rx = o.right_x;
      rz = o.right_z;
      o.up_x = q28_to_q14(dy * rz);
      o.up_y = q28_to_q14(dz * rx - dx * rz);
      o.up_z = q28_to_q14(-dy * rx);
    end else begin
      s = dz * dz + dy * dy;
      o.right_x = Q_ONE;
      o.up_y = unit_comp(dz, s);
      o.up_z = unit_comp(-dy, s);
    end
    return o;
  endfunction

  function automatic vec_row_t row(int x, int y, int z, bit has_exp = 0,
                                   int rx = 0, int rz = 0, int ux = 0,
                                   int uy = 0, int uz = 0);
    vec_row_t r;
    r.x = 16'(x);
    r.y = 16'(y);
    r.z = 16'(z);
    r.has_exp = has_exp;
    r.exp = '{16'(rx), 16'sd0, 16'(rz), 16'(ux), 16'(uy), 16'(uz)};
    return r;
  endfunction

  task automatic send_dir(in_t d, out_t exp);
    in_valid <= 1'b1;
    in_data <= d;
    basis_q.push_back(exp);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic in_t random_dir();
    in_t d;
    int  k;
    int  a;
    int  b;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      d = in_t'({$urandom, $urandom});
    end else if (k == 1) begin
      d.dir_x = 16'($urandom_range(0, 8) - 4);
      d.dir_y = $urandom_range(0, 1) ? 16'($urandom_range(16379, 16384))
                                     : -16'($urandom_range(16379, 16384));
      d.dir_z = 16'($urandom_range(0, 400) - 200);
    end else begin
      // near-unit vectors: pick two components, solve the third
      a = $urandom_range(0, 32768) - 16384;
      b = $urandom_range(0, 32768) - 16384;
      while (a * a + b * b > 16384 * 16384) b = b / 2;
      d.dir_x = 16'(a);
      d.dir_y = 16'(b);
      d.dir_z = 16'($rtoi($sqrt(real'(16384 * 16384 - a * a - b * b))));
      if ($urandom_range(0, 1)) d.dir_z = -d.dir_z;
      if (k == 2) d = '{d.dir_z, d.dir_x, d.dir_y};
    end
    return d;
  endfunction

  initial begin
    vec_row_t dirs[$];
    in_t      d;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stim_done = 1'b0;
    quiet = 1'b0;
    n_errors = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    dirs.push_back(row(0, 0, 0, 1));
    dirs.push_back(row(0, 16384, 0, 1, 16384, 0, 0, 0, -16384));
    dirs.push_back(row(0, -16384, 0, 1, 16384, 0, 0, 0, 16384));
    dirs.push_back(row(0, 0, 16384, 1, 16384, 0, 0, 16384, 0));
    dirs.push_back(row(16384, 0, 0, 1, 0, -16384, 0, 16384, 0));
    dirs.push_back(row(-16384, 0, 0, 1, 0, 16384, 0, 16384, 0));
    dirs.push_back(row(0, 0, -16384, 1, -16384, 0, 0, 16384, 0));
    dirs.push_back(row(0, 16382, 0, 1));
    dirs.push_back(row(0, 16383, 0));
    dirs.push_back(row(0, -16383, 0));
    dirs.push_back(row(0, 16382, 100));
    dirs.push_back(row(0, -16382, -100));
    dirs.push_back(row(100, 16383, 2));
    dirs.push_back(row(9459, 9459, 9459));
    dirs.push_back(row(-9459, 9459, -9459));
    dirs.push_back(row(32767, 32767, 32767));
    dirs.push_back(row(-32768, -32768, -32768));
    dirs.push_back(row(-32768, 0, 32767));
    dirs.push_back(row(1, 0, 1));
    dirs.push_back(row(5, 20000, -7));
    dirs.push_back(row(16'hAAAA, 16'h5555, 16'hFFFF));
    foreach (dirs[i]) begin
      d = '{dirs[i].x, dirs[i].y, dirs[i].z};
      if (dirs[i].has_exp) send_dir(d, dirs[i].exp);
      else send_dir(d, predict_basis(d));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 150) quiet = 1'b1;
      gap();
      d = random_dir();
      send_dir(d, predict_basis(d));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int n;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && basis_q.size() > 10) begin
        out_ready <= 1'b0;
        n = 0;
        while (n < 80) begin
          @(posedge clk);
          n++;
        end
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (basis_q.size() == 0) begin
        $error("unexpected word %h", out_data);
        n_errors++;
      end else begin
        e = basis_q.pop_front();
        if (out_data.right_x !== e.right_x) begin
          $error("right_x exp %0d got %0d", e.right_x, out_data.right_x); n_errors++;
        end
        if (out_data.right_y !== e.right_y) begin
          $error("right_y exp %0d got %0d", e.right_y, out_data.right_y); n_errors++;
        end
        if (out_data.right_z !== e.right_z) begin
          $error("right_z exp %0d got %0d", e.right_z, out_data.right_z); n_errors++;
        end
        if (out_data.up_x !== e.up_x) begin
          $error("up_x exp %0d got %0d", e.up_x, out_data.up_x); n_errors++;
        end
        if (out_data.up_y !== e.up_y) begin
          $error("up_y exp %0d got %0d", e.up_y, out_data.up_y); n_errors++;
        end
        if (out_data.up_z !== e.up_z) begin
          $error("up_z exp %0d got %0d", e.up_z, out_data.up_z); n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    while (!(stim_done && basis_q.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
    end else begin
      repeat (LATENCY + QUIET_TAIL) @(posedge clk);
      if (n_errors == 0 && basis_q.size() == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule
`default_nettype wire
